[hdl/skvt_pkg.sv]
package skvt_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int SLOT_W   = KEY_W + VALUE_W;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_req;
        logic                ram_we;
        logic [IDX_W-1:0]    ram_waddr;
        logic [IDX_W-1:0]    ram_raddr;
        logic                wsel_new;
        logic                set_hit;
        logic                load_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              slot_eq;
        logic              slot_lt;
    } t_dp_stat;

endpackage

[hdl/sorted_key_value_table_core.sv]
// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------------------------
// request   i_valid / o_stall      i_mode, i_req_key, i_req_value
// result    o_valid / i_stall      o_status, o_hit_key, o_hit_value, o_entry_count
//
// The slot store has one read and one write port, so the scan and the shift move
// one slot per cycle. Reset empties the table at once, with no clearing pass.
// A finished result waits in the output register while i_stall is high; the next
// request is taken and worked on meanwhile, then waits to load that register.
module sorted_key_value_table_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [skvt_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [skvt_pkg::KEY_W-1:0]    i_req_key,
    input  logic signed [skvt_pkg::VALUE_W-1:0]  i_req_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [skvt_pkg::STATUS_W-1:0]        o_status,
    output logic signed [skvt_pkg::KEY_W-1:0]    o_hit_key,
    output logic signed [skvt_pkg::VALUE_W-1:0]  o_hit_value,
    output logic [skvt_pkg::COUNT_W-1:0]         o_entry_count
);

    skvt_pkg::t_dp_cmd  cmd;
    skvt_pkg::t_dp_stat stat;

    skvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    skvt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_mode        (i_mode),
        .i_req_key     (i_req_key),
        .i_req_value   (i_req_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_hit_key     (o_hit_key),
        .o_hit_value   (o_hit_value),
        .o_entry_count (o_entry_count)
    );

endmodule

[hdl/skvt_ram.sv]
module skvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/skvt_datapath.sv]
module skvt_datapath (
    input  logic                                 i_clk,
    input  logic [skvt_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [skvt_pkg::KEY_W-1:0]    i_req_key,
    input  logic signed [skvt_pkg::VALUE_W-1:0]  i_req_value,
    input  skvt_pkg::t_dp_cmd                    i_cmd,
    output skvt_pkg::t_dp_stat                   o_stat,
    output logic [skvt_pkg::STATUS_W-1:0]        o_status,
    output logic signed [skvt_pkg::KEY_W-1:0]    o_hit_key,
    output logic signed [skvt_pkg::VALUE_W-1:0]  o_hit_value,
    output logic [skvt_pkg::COUNT_W-1:0]         o_entry_count
);

    logic [skvt_pkg::MODE_W-1:0]         r_mode;
    logic signed [skvt_pkg::KEY_W-1:0]   r_key;
    logic signed [skvt_pkg::VALUE_W-1:0] r_value;
    logic signed [skvt_pkg::KEY_W-1:0]   r_hit_key;
    logic signed [skvt_pkg::VALUE_W-1:0] r_hit_value;
    logic [skvt_pkg::STATUS_W-1:0]       r_out_status;
    logic signed [skvt_pkg::KEY_W-1:0]   r_out_key;
    logic signed [skvt_pkg::VALUE_W-1:0] r_out_value;
    logic [skvt_pkg::COUNT_W-1:0]        r_out_count;

    logic [skvt_pkg::SLOT_W-1:0]         rd_slot;
    logic [skvt_pkg::SLOT_W-1:0]         wr_slot;
    logic signed [skvt_pkg::KEY_W-1:0]   slot_key;
    logic signed [skvt_pkg::VALUE_W-1:0] slot_value;

    // Slot store: key in the upper half, value in the lower half
    skvt_ram #(
        .WIDTH(skvt_pkg::SLOT_W),
        .DEPTH(skvt_pkg::CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_cmd.ram_waddr),
        .i_wdata (wr_slot),
        .i_raddr (i_cmd.ram_raddr),
        .o_rdata (rd_slot)
    );

    assign slot_key   = rd_slot[skvt_pkg::SLOT_W-1:skvt_pkg::VALUE_W];
    assign slot_value = rd_slot[skvt_pkg::VALUE_W-1:0];

    // Write either the new pair or the slot just read (shift by one)
    assign wr_slot = i_cmd.wsel_new ? {r_key, r_value} : rd_slot;

    // Compare the slot read back against the request key
    assign o_stat.mode    = r_mode;
    assign o_stat.slot_eq = (slot_key == r_key);
    assign o_stat.slot_lt = (slot_key < r_key);

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode  <= i_mode;
            r_key   <= i_req_key;
            r_value <= i_req_value;
        end
    end

    // Hold the matching pair, zero when nothing matched
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_hit_key   <= '0;
            r_hit_value <= '0;
        end else if (i_cmd.set_hit) begin
            r_hit_key   <= slot_key;
            r_hit_value <= slot_value;
        end
    end

    // Output register for the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.status;
            r_out_key    <= r_hit_key;
            r_out_value  <= r_hit_value;
            r_out_count  <= i_cmd.count;
        end
    end

    assign o_status      = r_out_status;
    assign o_hit_key     = r_out_key;
    assign o_hit_value   = r_out_value;
    assign o_entry_count = r_out_count;

endmodule

[hdl/skvt_ctrl.sv]
module skvt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  skvt_pkg::t_dp_stat i_stat,
    output skvt_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_INS_SCAN = 3'd2;
    localparam logic [2:0] S_INS_HEAD = 3'd3;
    localparam logic [2:0] S_FIND     = 3'd4;
    localparam logic [2:0] S_SHIFT    = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [skvt_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [skvt_pkg::OCC_W-1:0]    r_occ, n_occ;
    logic [skvt_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_out_valid, n_out_valid;

    logic [skvt_pkg::OCC_W-1:0]    idx_p1;
    logic                          more;

    // Next slot index and whether it is still inside the table
    assign idx_p1 = skvt_pkg::OCC_W'(r_idx) + skvt_pkg::OCC_W'(1);
    assign more   = (idx_p1 < r_occ);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_occ       = r_occ;
        n_status    = r_status;
        n_out_valid = r_out_valid;

        o_cmd           = '0;
        o_cmd.ram_raddr = r_idx;
        o_cmd.status    = r_status;
        o_cmd.count     = skvt_pkg::COUNT_W'(r_occ);

        // Drop the output beat once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_START;
                end
            end

            S_START: begin
                n_status = skvt_pkg::ST_MISSING;
                n_state  = S_RESP;
                if (i_stat.mode == skvt_pkg::MODE_INSERT) begin
                    if (r_occ == skvt_pkg::OCC_W'(skvt_pkg::CAPACITY)) begin
                        n_status = skvt_pkg::ST_FULL;
                    end else if (r_occ == '0) begin
                        o_cmd.ram_we    = 1'b1;
                        o_cmd.ram_waddr = '0;
                        o_cmd.wsel_new  = 1'b1;
                        n_occ           = r_occ + skvt_pkg::OCC_W'(1);
                        n_status        = skvt_pkg::ST_OK;
                    end else begin
                        // Start the downward scan at the last slot
                        o_cmd.ram_raddr = skvt_pkg::IDX_W'(r_occ - skvt_pkg::OCC_W'(1));
                        n_idx           = skvt_pkg::IDX_W'(r_occ - skvt_pkg::OCC_W'(1));
                        n_state         = S_INS_SCAN;
                    end
                end else if (i_stat.mode == skvt_pkg::MODE_SEARCH ||
                             i_stat.mode == skvt_pkg::MODE_REMOVE) begin
                    if (r_occ != '0) begin
                        o_cmd.ram_raddr = '0;
                        n_idx           = '0;
                        n_state         = S_FIND;
                    end
                end
            end

            S_INS_SCAN: begin
                o_cmd.ram_we    = 1'b1;
                o_cmd.ram_waddr = skvt_pkg::IDX_W'(idx_p1);
                if (i_stat.slot_lt) begin
                    // Slot below the new pair found: place it above
                    o_cmd.wsel_new = 1'b1;
                    n_occ          = r_occ + skvt_pkg::OCC_W'(1);
                    n_status       = skvt_pkg::ST_OK;
                    n_state        = S_RESP;
                end else if (r_idx == '0) begin
                    n_state = S_INS_HEAD;
                end else begin
                    // Shift this slot up and read the one below
                    o_cmd.ram_raddr = r_idx - skvt_pkg::IDX_W'(1);
                    n_idx           = r_idx - skvt_pkg::IDX_W'(1);
                end
            end

            S_INS_HEAD: begin
                o_cmd.ram_we    = 1'b1;
                o_cmd.ram_waddr = '0;
                o_cmd.wsel_new  = 1'b1;
                n_occ           = r_occ + skvt_pkg::OCC_W'(1);
                n_status        = skvt_pkg::ST_OK;
                n_state         = S_RESP;
            end

            S_FIND: begin
                if (i_stat.slot_eq) begin
                    o_cmd.set_hit = 1'b1;
                    n_status      = skvt_pkg::ST_OK;
                    if (i_stat.mode == skvt_pkg::MODE_SEARCH) begin
                        n_state = S_RESP;
                    end else if (more) begin
                        o_cmd.ram_raddr = skvt_pkg::IDX_W'(idx_p1);
                        n_idx           = skvt_pkg::IDX_W'(idx_p1);
                        n_state         = S_SHIFT;
                    end else begin
                        n_occ   = r_occ - skvt_pkg::OCC_W'(1);
                        n_state = S_RESP;
                    end
                end else if (more) begin
                    o_cmd.ram_raddr = skvt_pkg::IDX_W'(idx_p1);
                    n_idx           = skvt_pkg::IDX_W'(idx_p1);
                end else begin
                    n_status = skvt_pkg::ST_MISSING;
                    n_state  = S_RESP;
                end
            end

            S_SHIFT: begin
                // Close the gap: move this slot down by one
                o_cmd.ram_we    = 1'b1;
                o_cmd.ram_waddr = r_idx - skvt_pkg::IDX_W'(1);
                if (more) begin
                    o_cmd.ram_raddr = skvt_pkg::IDX_W'(idx_p1);
                    n_idx           = skvt_pkg::IDX_W'(idx_p1);
                end else begin
                    n_occ   = r_occ - skvt_pkg::OCC_W'(1);
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                // Load the output register once it is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule
